[hdl/egcd_pkg.sv]
// shared constants, types and controller states for the extended gcd core
`default_nettype none
package egcd_pkg;

    localparam int VALUE_BITS = 31;
    localparam int COEF_BITS  = VALUE_BITS + 1;
    localparam int SUM_BITS   = VALUE_BITS + 2;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_INV_SUM,
        ST_INV_RED1,
        ST_INV_RED2,
        ST_DONE
    } egcd_state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic inv_sum;
        logic inv_red;
        logic out_load;
    } egcd_cmd_t;

    typedef struct packed {
        logic a_zero;
        logic out_busy;
    } egcd_status_t;

endpackage
`default_nettype wire

[hdl/egcd_datapath.sv]
// datapath: operands, bit-serial divider with quotient-times-coefficient accumulators, output register
`default_nettype none
module egcd_datapath
    import egcd_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire egcd_cmd_t                    cmd,
    output egcd_status_t                      status,
    input  wire logic [VALUE_BITS-1:0]        value_a,
    input  wire logic [VALUE_BITS-1:0]        modulus_b,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output logic [VALUE_BITS-1:0]             gcd_value,
    output logic signed [COEF_BITS-1:0]       coef_a,
    output logic signed [COEF_BITS-1:0]       coef_b,
    output logic [VALUE_BITS-1:0]             inverse
);

    logic [VALUE_BITS-1:0] a_reg, b_reg, m_reg, shift_reg, part_reg;
    logic [COEF_BITS-1:0]  xa_reg, ya_reg, xb_reg, yb_reg, accx_reg, accy_reg;
    logic [SUM_BITS-1:0]   s_reg;
    logic                  out_valid_reg;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic                  qbit;
    logic [SUM_BITS-1:0]   m_ext;

    always_comb
    begin
        trial = {part_reg, shift_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, a_reg};
        qbit  = (trial >= {1'b0, a_reg});
        m_ext = {2'b00, m_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg  <= value_a;
            b_reg  <= modulus_b;
            m_reg  <= modulus_b;
            xa_reg <= COEF_BITS'(1);
            ya_reg <= '0;
            xb_reg <= '0;
            yb_reg <= COEF_BITS'(1);
        end
        if (cmd.div_init)
        begin
            part_reg  <= '0;
            shift_reg <= b_reg;
            accx_reg  <= '0;
            accy_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            part_reg  <= qbit ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            shift_reg <= {shift_reg[VALUE_BITS-2:0], 1'b0};
            accx_reg  <= {accx_reg[COEF_BITS-2:0], 1'b0} + (qbit ? xa_reg : '0);
            accy_reg  <= {accy_reg[COEF_BITS-2:0], 1'b0} + (qbit ? ya_reg : '0);
        end
        if (cmd.update)
        begin
            xa_reg <= xb_reg - accx_reg;
            ya_reg <= yb_reg - accy_reg;
            xb_reg <= xa_reg;
            yb_reg <= ya_reg;
            b_reg  <= a_reg;
            a_reg  <= part_reg;
        end
        if (cmd.inv_sum)
        begin
            s_reg <= {xb_reg[COEF_BITS-1], xb_reg} + m_ext;
        end
        if (cmd.inv_red)
        begin
            if (s_reg >= m_ext)
            begin
                s_reg <= s_reg - m_ext;
            end
        end
        if (cmd.out_load)
        begin
            gcd_value <= b_reg;
            coef_a    <= xb_reg;
            coef_b    <= yb_reg;
            inverse   <= (m_reg == '0) ? '0 : s_reg[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.a_zero   = (a_reg == '0);
    assign status.out_busy = out_valid_reg && out_stall;

endmodule
`default_nettype wire

[hdl/egcd_controller.sv]
// controller: sequences load, division rounds, coefficient updates and inverse reduction
`default_nettype none
module egcd_controller
    import egcd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire egcd_status_t status,
    output egcd_cmd_t         cmd
);

    egcd_state_t         state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.a_zero)
                begin
                    state_next = ST_INV_SUM;
                end
                else
                begin
                    state_next = ST_DIV;
                    cnt_next   = CNT_LAST;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
            end
            ST_UPDATE:   state_next = ST_CHECK;
            ST_INV_SUM:  state_next = ST_INV_RED1;
            ST_INV_RED1: state_next = ST_INV_RED2;
            ST_INV_RED2: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CHECK:    cmd.div_init = !status.a_zero;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_UPDATE:   cmd.update   = 1'b1;
            ST_INV_SUM:  cmd.inv_sum  = 1'b1;
            ST_INV_RED1: cmd.inv_red  = 1'b1;
            ST_INV_RED2: cmd.inv_red  = 1'b1;
            ST_DONE:     cmd.out_load = !status.out_busy;
            default:     cmd          = '0;
        endcase
    end

endmodule
`default_nettype wire

[hdl/extended_gcd_mod_inverse_core.sv]
// top level of the extended gcd and modular inverse core
// sequence: per euclid round a check, a bit-serial division at one quotient bit per cycle and an
// update; when a reaches zero, an inverse sum and its reduction, then the result is loaded into
// the output register once that register is no longer held by out_stall
// throughput: one transaction at a time; the next input is taken while a result waits
// reset: rst_n clears the controller and the output valid flag, payload is not reset
`default_nettype none
module extended_gcd_mod_inverse_core
    import egcd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [VALUE_BITS-1:0]  value_a,
    input  wire logic [VALUE_BITS-1:0]  modulus_b,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [VALUE_BITS-1:0]       gcd_value,
    output logic signed [COEF_BITS-1:0] coef_a,
    output logic signed [COEF_BITS-1:0] coef_b,
    output logic [VALUE_BITS-1:0]       inverse
);

    egcd_cmd_t    cmd;
    egcd_status_t status;

    egcd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    egcd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value_a   (value_a),
        .modulus_b (modulus_b),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .gcd_value (gcd_value),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .inverse   (inverse)
    );

endmodule
`default_nettype wire
